[rtl/huc_pkg.sv]
package huc_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int INDEX_BITS        = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int BACK_STAGES       = 3;
    localparam int REG_INDEX_BITS    = 2;

    // golden ratio conjugate as a 32-bit fraction of a turn
    localparam longint unsigned GOLDEN_Q32 = 64'd2654435769;

    typedef enum logic
    {
        CMD_CONVERT = 1'b0,
        CMD_UNIQUE  = 1'b1
    } command_t;

    typedef enum logic [REG_INDEX_BITS-1:0]
    {
        REG_START_HUE  = 2'd0,
        REG_HUE_STEP   = 2'd1,
        REG_SATURATION = 2'd2,
        REG_VALUE      = 2'd3
    } reg_index_t;

    // sextant of the hue circle, named by the colors at its two ends
    typedef enum logic [2:0]
    {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } sextant_t;

endpackage

[rtl/huc_in_if.sv]
interface huc_in_if #(
    parameter int FRAC_BITS = huc_pkg::DEFAULT_FRAC_BITS
);
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [FRAC_BITS-1:0]            hue;
    logic [FRAC_BITS:0]              saturation;
    logic [FRAC_BITS:0]              brightness;
    logic [huc_pkg::INDEX_BITS-1:0]  color_index;

    modport source
    (
        output valid, command, hue, saturation, brightness, color_index,
        input  ready
    );

    modport sink
    (
        input  valid, command, hue, saturation, brightness, color_index,
        output ready
    );
endinterface

[rtl/huc_out_if.sv]
interface huc_out_if #(
    parameter int FRAC_BITS = huc_pkg::DEFAULT_FRAC_BITS
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] red;
    logic [FRAC_BITS:0] green;
    logic [FRAC_BITS:0] blue;

    modport source
    (
        output valid, red, green, blue,
        input  ready
    );

    modport sink
    (
        input  valid, red, green, blue,
        output ready
    );
endinterface

[rtl/huc_front.sv]
module huc_front #(
    parameter int FRAC_BITS = huc_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    huc_in_if.sink               request,
    input  logic [FRAC_BITS-1:0] start_hue,
    input  logic [FRAC_BITS-1:0] hue_step,
    input  logic [FRAC_BITS:0]   uniq_saturation,
    input  logic [FRAC_BITS:0]   uniq_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS-1:0] out_hue,
    output logic [FRAC_BITS:0]   out_saturation,
    output logic [FRAC_BITS:0]   out_value
);

    logic                   valid_reg;
    logic [FRAC_BITS-1:0]   hue_reg;
    logic [FRAC_BITS:0]     sat_reg;
    logic [FRAC_BITS:0]     val_reg;

    logic [2*FRAC_BITS-1:0] idx_prod;
    logic [FRAC_BITS-1:0]   hue_next;
    logic [FRAC_BITS:0]     sat_next;
    logic [FRAC_BITS:0]     val_next;
    logic                   advance;

    // only the low index bits matter for the product modulo one turn
    assign idx_prod = request.color_index[FRAC_BITS-1:0] * hue_step;

    always_comb
    begin
        if (huc_pkg::command_t'(request.command) == huc_pkg::CMD_UNIQUE)
        begin
            hue_next = start_hue + idx_prod[FRAC_BITS-1:0];
            sat_next = uniq_saturation;
            val_next = uniq_value;
        end
        else
        begin
            hue_next = request.hue;
            sat_next = request.saturation;
            val_next = request.brightness;
        end
    end

    assign advance       = !valid_reg || out_ready;
    assign request.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && request.valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_hue        = hue_reg;
    assign out_saturation = sat_reg;
    assign out_value      = val_reg;

endmodule

[rtl/huc_queue.sv]
module huc_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = huc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != COUNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/huc_back.sv]
module huc_back #(
    parameter int FRAC_BITS = huc_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FRAC_BITS-1:0] in_hue,
    input  logic [FRAC_BITS:0]   in_saturation,
    input  logic [FRAC_BITS:0]   in_value,
    huc_out_if.source            color
);

    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // stage a: sextant, fraction, chroma
    logic                    valid_a_reg;
    huc_pkg::sextant_t       sext_a_reg;
    logic [FRAC_BITS-1:0]    frac_a_reg;
    logic [FRAC_BITS+1:0]    c_a_reg;
    logic [FRAC_BITS:0]      v_a_reg;

    // stage b: secondary term and offset
    logic                    valid_b_reg;
    huc_pkg::sextant_t       sext_b_reg;
    logic [FRAC_BITS+1:0]    c_b_reg;
    logic [FRAC_BITS+1:0]    x_b_reg;
    logic signed [FRAC_BITS+2:0] m_b_reg;

    // stage c: output word
    logic                    valid_c_reg;
    logic [FRAC_BITS:0]      red_reg;
    logic [FRAC_BITS:0]      green_reg;
    logic [FRAC_BITS:0]      blue_reg;

    logic                    adv_a;
    logic                    adv_b;
    logic                    adv_c;

    logic [FRAC_BITS+2:0]    h6;
    logic [2*FRAC_BITS+1:0]  sv_prod;
    logic [FRAC_BITS:0]      t_b;
    logic [2*FRAC_BITS+2:0]  ct_prod;
    logic signed [FRAC_BITS+2:0] m_next;
    logic [FRAC_BITS+1:0]    r_pick;
    logic [FRAC_BITS+1:0]    g_pick;
    logic [FRAC_BITS+1:0]    b_pick;

    function automatic logic [FRAC_BITS:0] clamp_unit(
        input logic [FRAC_BITS+1:0]        pick,
        input logic signed [FRAC_BITS+2:0] offs
    );
        logic signed [FRAC_BITS+3:0] sum;
        logic [FRAC_BITS:0]          res;
        sum = $signed({2'b00, pick}) + $signed({offs[FRAC_BITS+2], offs});
        if (sum < 0)
        begin
            res = '0;
        end
        else if (sum > $signed({3'b000, ONE_Q}))
        begin
            res = ONE_Q;
        end
        else
        begin
            res = sum[FRAC_BITS:0];
        end
        return res;
    endfunction

    assign adv_c    = !valid_c_reg || color.ready;
    assign adv_b    = !valid_b_reg || adv_c;
    assign adv_a    = !valid_a_reg || adv_b;
    assign in_ready = adv_a;

    // hue times six as shift-add
    assign h6      = (FRAC_BITS+3)'({in_hue, 2'b00}) + (FRAC_BITS+3)'({in_hue, 1'b0});
    assign sv_prod = in_saturation * in_value;

    // odd sextants fall from chroma, even ones rise
    assign t_b     = sext_a_reg[0] ? (ONE_Q - {1'b0, frac_a_reg}) : {1'b0, frac_a_reg};
    assign ct_prod = c_a_reg * t_b;
    assign m_next  = $signed({2'b00, v_a_reg}) - $signed({1'b0, c_a_reg});

    always_comb
    begin
        unique case (sext_b_reg)
            huc_pkg::SEXT_RED_YEL:
            begin
                r_pick = c_b_reg; g_pick = x_b_reg; b_pick = '0;
            end
            huc_pkg::SEXT_YEL_GRN:
            begin
                r_pick = x_b_reg; g_pick = c_b_reg; b_pick = '0;
            end
            huc_pkg::SEXT_GRN_CYN:
            begin
                r_pick = '0; g_pick = c_b_reg; b_pick = x_b_reg;
            end
            huc_pkg::SEXT_CYN_BLU:
            begin
                r_pick = '0; g_pick = x_b_reg; b_pick = c_b_reg;
            end
            huc_pkg::SEXT_BLU_MAG:
            begin
                r_pick = x_b_reg; g_pick = '0; b_pick = c_b_reg;
            end
            default:
            begin
                r_pick = c_b_reg; g_pick = '0; b_pick = x_b_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (adv_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (adv_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            sext_a_reg <= huc_pkg::sextant_t'(h6[FRAC_BITS+2:FRAC_BITS]);
            frac_a_reg <= h6[FRAC_BITS-1:0];
            c_a_reg    <= sv_prod[2*FRAC_BITS+1:FRAC_BITS];
            v_a_reg    <= in_value;
        end
        if (adv_b && valid_a_reg)
        begin
            sext_b_reg <= sext_a_reg;
            c_b_reg    <= c_a_reg;
            x_b_reg    <= ct_prod[2*FRAC_BITS+1:FRAC_BITS];
            m_b_reg    <= m_next;
        end
        if (adv_c && valid_b_reg)
        begin
            red_reg   <= clamp_unit(r_pick, m_b_reg);
            green_reg <= clamp_unit(g_pick, m_b_reg);
            blue_reg  <= clamp_unit(b_pick, m_b_reg);
        end
    end

    assign color.valid = valid_c_reg;
    assign color.red   = red_reg;
    assign color.green = green_reg;
    assign color.blue  = blue_reg;

endmodule

[rtl/hsv_unique_color_generator.sv]
// channel  | dir | handshake      | word
// ---------+-----+----------------+------------------------------------------------
// request  | in  | valid / ready  | command, hue, saturation, brightness, color_index
// color    | out | valid / ready  | red, green, blue
// write    | in  | write_enable   | reg_index, write_data
//
// one word per cycle sustained while color is ready; a result passes the front stage, the
// queue, then three back stages before it shows on color, each multiplier
// (index times step, saturation times value, chroma times fraction) in a stage of its own
// a two-entry queue sits between front and back so each side stalls on its own
// rst_n clears all valid flags, queue pointers and loads the configuration defaults
module hsv_unique_color_generator #(
    parameter int FRAC_BITS = huc_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    huc_in_if.sink                             request,
    huc_out_if.source                          color,
    input  logic                               write_enable,
    input  logic [huc_pkg::REG_INDEX_BITS-1:0] reg_index,
    input  logic [FRAC_BITS:0]                 write_data
);

    localparam longint unsigned ONE_L     = 64'd1 << FRAC_BITS;
    localparam longint unsigned HUE_MASK  = ONE_L - 64'd1;
    localparam longint unsigned RST_START = ((ONE_L * 64'd3) + 64'd5) / 64'd10 & HUE_MASK;
    localparam longint unsigned RST_STEP  = (huc_pkg::GOLDEN_Q32 >> (32 - FRAC_BITS)) & HUE_MASK;
    localparam longint unsigned RST_SAT   = ((ONE_L * 64'd17) + 64'd10) / 64'd20;
    localparam int QWIDTH     = 3 * FRAC_BITS + 2;
    localparam int CAPACITY   = 1 + huc_pkg::QUEUE_DEPTH + huc_pkg::BACK_STAGES;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS-1:0] start_hue_reg;
    logic [FRAC_BITS-1:0] hue_step_reg;
    logic [FRAC_BITS:0]   saturation_reg;
    logic [FRAC_BITS:0]   value_reg;

    logic                 fq_valid;
    logic                 fq_ready;
    logic [FRAC_BITS-1:0] fq_hue;
    logic [FRAC_BITS:0]   fq_sat;
    logic [FRAC_BITS:0]   fq_val;
    logic                 qb_valid;
    logic                 qb_ready;
    logic [QWIDTH-1:0]    qb_data;

    logic [CNT_BITS-1:0]  inflight_reg;
    logic                 in_take;
    logic                 out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hue_reg  <= FRAC_BITS'(RST_START);
            hue_step_reg   <= FRAC_BITS'(RST_STEP);
            saturation_reg <= (FRAC_BITS+1)'(RST_SAT);
            value_reg      <= ONE_Q;
        end
        else if (write_enable)
        begin
            unique case (huc_pkg::reg_index_t'(reg_index))
                huc_pkg::REG_START_HUE:  start_hue_reg  <= write_data[FRAC_BITS-1:0];
                huc_pkg::REG_HUE_STEP:   hue_step_reg   <= write_data[FRAC_BITS-1:0];
                huc_pkg::REG_SATURATION: saturation_reg <= write_data;
                huc_pkg::REG_VALUE:      value_reg      <= write_data;
                default: ;
            endcase
        end
    end

    huc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .request         (request),
        .start_hue       (start_hue_reg),
        .hue_step        (hue_step_reg),
        .uniq_saturation (saturation_reg),
        .uniq_value      (value_reg),
        .out_valid       (fq_valid),
        .out_ready       (fq_ready),
        .out_hue         (fq_hue),
        .out_saturation  (fq_sat),
        .out_value       (fq_val)
    );

    huc_queue #(
        .WIDTH (QWIDTH),
        .DEPTH (huc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_hue, fq_sat, fq_val}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    huc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_hue        (qb_data[QWIDTH-1 -: FRAC_BITS]),
        .in_saturation (qb_data[2*FRAC_BITS+1 -: FRAC_BITS+1]),
        .in_value      (qb_data[FRAC_BITS:0]),
        .color         (color)
    );

    // words taken but not yet delivered
    assign in_take  = request.valid && request.ready;
    assign out_take = color.valid && color.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            inflight_reg <= inflight_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    a_no_phantom_output: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid |-> (inflight_reg != '0))
        else $error("color word without a pending request");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_BITS'(CAPACITY))
        else $error("more words in flight than storage holds");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid |-> (color.red <= ONE_Q && color.green <= ONE_Q && color.blue <= ONE_Q))
        else $error("color component above one");

    a_value_write: assert property (@(posedge clk) disable iff (!rst_n)
        (write_enable && reg_index == huc_pkg::REG_VALUE) |=> (value_reg == $past(write_data)))
        else $error("value register write lost");

endmodule

[verif/tb_hsv_unique_color_generator.sv]
`timescale 1ns / 100ps

module tb_hsv_unique_color_generator;

    localparam int F = huc_pkg::DEFAULT_FRAC_BITS;
    localparam longint unsigned ONE = 64'd1 << F;
    localparam bit [F:0] ONE_Q = {1'b1, {F{1'b0}}};
    localparam int TIMEOUT_CYCLES = 500_000;

    typedef struct packed
    {
        bit [F:0] red;
        bit [F:0] green;
        bit [F:0] blue;
    } rgb_t;

    logic                               clk;
    logic                               rst_n;
    logic                               write_enable;
    logic [huc_pkg::REG_INDEX_BITS-1:0] reg_index;
    logic [F:0]                         write_data;

    huc_in_if  #(.FRAC_BITS(F)) request ();
    huc_out_if #(.FRAC_BITS(F)) color ();

    hsv_unique_color_generator #(
        .FRAC_BITS(F)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .color        (color),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // local copy of the index-mode registers, starting at the reset defaults
    bit [F-1:0] unique_start = F'((ONE * 3 + 5) / 10);
    bit [F-1:0] unique_step  = F'((huc_pkg::GOLDEN_Q32 << F) >> 32);
    bit [F:0]   unique_sat   = (F+1)'((ONE * 17 + 10) / 20);
    bit [F:0]   unique_val   = ONE_Q;

    rgb_t expected_colors[$];
    int   error_count     = 0;
    bit   source_gaps     = 1'b1;
    bit   sink_stalls     = 1'b1;
    int   hold_off_cycles = 0;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(20 * TIMEOUT_CYCLES);
        $display("tb_hsv_unique_color_generator: done, errors");
        $finish;
    end

    function automatic bit [F:0] clamp_unit(input longint level);
        if (level < 0)
            return '0;
        if (level > longint'(ONE))
            return ONE_Q;
        return level[F:0];
    endfunction

    function automatic rgb_t hsv_to_rgb(input bit [F-1:0] hue, input bit [F:0] sat,
                                        input bit [F:0] val);
        longint unsigned   hue6;
        longint unsigned   frac;
        longint unsigned   chroma;
        longint unsigned   span;
        longint unsigned   second;
        longint            offset;
        longint            r;
        longint            g;
        longint            b;
        bit [2:0]          sext_bits;
        huc_pkg::sextant_t sextant;
        rgb_t              rgb;

        hue6      = 64'(hue);
        hue6      = hue6 * 6;
        sext_bits = 3'(hue6 >> F);
        sextant   = huc_pkg::sextant_t'(sext_bits);
        frac      = hue6 & (ONE - 1);
        chroma    = 64'(sat);
        chroma    = (chroma * 64'(val)) >> F;
        span      = sext_bits[0] ? ONE - frac : frac;
        second    = (chroma * span) >> F;
        // saturation above one can push chroma past value
        offset    = longint'(val) - longint'(chroma);
        case (sextant)
            huc_pkg::SEXT_RED_YEL:
            begin
                r = chroma; g = second; b = 0;
            end
            huc_pkg::SEXT_YEL_GRN:
            begin
                r = second; g = chroma; b = 0;
            end
            huc_pkg::SEXT_GRN_CYN:
            begin
                r = 0; g = chroma; b = second;
            end
            huc_pkg::SEXT_CYN_BLU:
            begin
                r = 0; g = second; b = chroma;
            end
            huc_pkg::SEXT_BLU_MAG:
            begin
                r = second; g = 0; b = chroma;
            end
            default:
            begin
                r = chroma; g = 0; b = second;
            end
        endcase
        rgb.red   = clamp_unit(r + offset);
        rgb.green = clamp_unit(g + offset);
        rgb.blue  = clamp_unit(b + offset);
        return rgb;
    endfunction

    function automatic rgb_t predict_color(input huc_pkg::command_t cmd, input bit [F-1:0] hue,
                                           input bit [F:0] sat, input bit [F:0] bri,
                                           input bit [31:0] idx);
        longint unsigned turn;

        if (cmd == huc_pkg::CMD_UNIQUE)
        begin
            // exact modular product: only the low fraction bits survive
            turn = 64'(idx);
            turn = turn * 64'(unique_step) + 64'(unique_start);
            return hsv_to_rgb(turn[F-1:0], unique_sat, unique_val);
        end
        return hsv_to_rgb(hue, sat, bri);
    endfunction

    // saturation and value levels, now and then above one
    function automatic bit [F:0] random_level();
        int unsigned pick;

        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ONE_Q;
        if (pick < 4)
            return (F+1)'($urandom_range(0, 131071));
        return (F+1)'($urandom_range(0, 65536));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && request.valid && request.ready)
            expected_colors.push_back(predict_color(huc_pkg::command_t'(request.command),
                                                    request.hue, request.saturation,
                                                    request.brightness, request.color_index));
    end

    always @(posedge clk)
    begin : check_color
        rgb_t want;

        if (rst_n && color.valid && color.ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("unexpected color word: red %0d green %0d blue %0d",
                       color.red, color.green, color.blue);
                error_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (color.red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, color.red);
                    error_count++;
                end
                if (color.green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, color.green);
                    error_count++;
                end
                if (color.blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, color.blue);
                    error_count++;
                end
            end
        end
    end

    // color sink: ready runs, stall bursts, and a long hold-off on request
    initial
    begin : color_sink
        color.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                color.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                color.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                color.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input huc_pkg::command_t cmd, input bit [F-1:0] hue,
                                input bit [F:0] sat, input bit [F:0] bri,
                                input bit [31:0] idx);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            request.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        request.valid       <= 1'b1;
        request.command     <= cmd;
        request.hue         <= hue;
        request.saturation  <= sat;
        request.brightness  <= bri;
        request.color_index <= idx;
        do
            @(posedge clk);
        while (!request.ready);
    endtask

    task automatic send_random_request();
        huc_pkg::command_t cmd;

        cmd = $urandom_range(0, 1) ? huc_pkg::CMD_UNIQUE : huc_pkg::CMD_CONVERT;
        send_request(cmd, F'($urandom), random_level(), random_level(), $urandom);
    endtask

    task automatic wait_colors_drained();
        request.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_colors.size() != 0);
    endtask

    // writes all four registers back to back; only called with nothing in flight
    task automatic write_settings(input bit [F:0] start_word, input bit [F:0] step_word,
                                  input bit [F:0] sat_word, input bit [F:0] val_word);
        huc_pkg::reg_index_t regs [4];
        bit [F:0]            data [4];

        regs = '{huc_pkg::REG_START_HUE, huc_pkg::REG_HUE_STEP, huc_pkg::REG_SATURATION,
                 huc_pkg::REG_VALUE};
        data = '{start_word, step_word, sat_word, val_word};
        for (int i = 0; i < 4; i++)
        begin
            write_enable <= 1'b1;
            reg_index    <= regs[i];
            write_data   <= data[i];
            @(posedge clk);
            case (regs[i])
                huc_pkg::REG_START_HUE:  unique_start = data[i][F-1:0];
                huc_pkg::REG_HUE_STEP:   unique_step  = data[i][F-1:0];
                huc_pkg::REG_SATURATION: unique_sat   = data[i];
                huc_pkg::REG_VALUE:      unique_val   = data[i];
            endcase
        end
        write_enable <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(huc_pkg::CMD_UNIQUE, '0, '0, '0, 32'd0);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(), 32'd1);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(),
                     32'hFFFF_FFFF);
        wait_colors_drained();
    endtask

    task automatic test_convert_extremes();
        bit [F-1:0] hues [8];
        bit [F:0]   sats [6];
        bit [F:0]   bris [6];

        // hue ends, the last hue before the first sextant border and the first hue of each later sextant
        hues = '{16'd0, 16'd10922, 16'd10923, 16'd21846, 16'd32768, 16'd43691,
                 16'd54614, 16'd65535};
        sats = '{17'd0, 17'd65536, 17'd131071, 17'd131071, 17'd65536, 17'd32768};
        bris = '{17'd65536, 17'd0, 17'd131071, 17'd65536, 17'd131071, 17'd49152};
        foreach (hues[i])
            send_request(huc_pkg::CMD_CONVERT, hues[i], ONE_Q, ONE_Q, $urandom);
        foreach (sats[i])
            send_request(huc_pkg::CMD_CONVERT, F'($urandom), sats[i], bris[i], $urandom);
        wait_colors_drained();
    endtask

    task automatic test_register_extremes();
        write_settings('0, '0, '0, '0);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(), 32'd0);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(),
                     32'hFFFF_FFFF);
        wait_colors_drained();
        // top bit of the hue registers is dropped by the block
        write_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(), 32'd0);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(),
                     32'hFFFF_FFFF);
        wait_colors_drained();
        write_settings('0, 17'd1, ONE_Q, ONE_Q);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(),
                     32'd65535);
        send_request(huc_pkg::CMD_UNIQUE, F'($urandom), random_level(), random_level(),
                     $urandom);
        wait_colors_drained();
    endtask

    task automatic test_random_traffic();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        repeat (5)
        begin
            write_settings((F+1)'($urandom_range(0, 131071)), (F+1)'($urandom_range(0, 131071)),
                           random_level(), random_level());
            repeat (340) send_random_request();
            wait_colors_drained();
        end
    endtask

    task automatic test_backpressure();
        source_gaps     = 1'b0;
        hold_off_cycles = 80;
        repeat (40) send_random_request();
        wait_colors_drained();
    endtask

    task automatic test_full_rate();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_settings((F+1)'($urandom_range(0, 131071)), (F+1)'($urandom_range(0, 131071)),
                       random_level(), random_level());
        repeat (100) send_random_request();
        wait_colors_drained();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        request.valid       <= 1'b0;
        request.command     <= huc_pkg::CMD_CONVERT;
        request.hue         <= '0;
        request.saturation  <= '0;
        request.brightness  <= '0;
        request.color_index <= '0;
        write_enable        <= 1'b0;
        reg_index           <= huc_pkg::REG_START_HUE;
        write_data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_convert_extremes();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_full_rate();

        // catch stray words after the last one expected
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_hsv_unique_color_generator: done, clean");
        else
            $display("tb_hsv_unique_color_generator: done, errors");
        $finish;
    end

endmodule
